// File: hdl/mopc_pkg.sv
// shared constants and arithmetic helpers for the mask overlay pixel colorizer
package mopc_pkg;

    // view mode codes
    localparam logic [2:0] VIEW_FULL     = 3'd0;
    localparam logic [2:0] VIEW_RED      = 3'd1;
    localparam logic [2:0] VIEW_GREEN    = 3'd2;
    localparam logic [2:0] VIEW_BLUE     = 3'd3;
    localparam logic [2:0] VIEW_SEMANTIC = 3'd4;

    // texture kind codes
    localparam logic [2:0] KIND_SHADOW    = 3'd0;
    localparam logic [2:0] KIND_SUBLIGHT  = 3'd1;
    localparam logic [2:0] KIND_EDGE      = 3'd2;
    localparam logic [2:0] KIND_FACE_DIST = 3'd3;
    localparam logic [2:0] KIND_PASS      = 3'd4;

    // register index, taken from paddr[2]
    localparam logic REG_VIEW_MODE    = 1'b0;
    localparam logic REG_TEXTURE_KIND = 1'b1;

    localparam logic [2:0] VIEW_MODE_RESET    = VIEW_FULL;
    localparam logic [2:0] TEXTURE_KIND_RESET = KIND_PASS;

    // tint coefficients
    localparam logic [7:0] COEF_R220 = 8'd220;
    localparam logic [7:0] COEF_G235 = 8'd235;
    localparam logic [7:0] COEF_R240 = 8'd240;
    localparam logic [7:0] COEF_R140 = 8'd140;
    localparam logic [7:0] COEF_G230 = 8'd230;

    // fixed colors and offsets
    localparam logic [7:0] LEVEL_FULL  = 8'd255;
    localparam logic [7:0] LEVEL_80    = 8'd80;
    localparam logic [7:0] LEVEL_100   = 8'd100;
    localparam logic [7:0] LEVEL_140   = 8'd140;
    localparam logic [7:0] EDGE_OFS_G  = 8'd40;
    localparam logic [7:0] EDGE_OFS_B  = 8'd60;

    localparam int NUM_LANES = 3;

    typedef logic [NUM_LANES-1:0][7:0]  lane_byte_t;
    typedef logic [NUM_LANES-1:0][15:0] lane_word_t;

    // floor(x / 255) for x up to 255*255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return s[15:8];
    endfunction

    // clamp a 9-bit sum at 255
    function automatic logic [7:0] sat8(input logic [8:0] x);
        return x[8] ? LEVEL_FULL : x[7:0];
    endfunction

    function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        logic [7:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // one restoring division step: upper byte is the partial remainder, lower
    // byte shifts dividend bits out and quotient bits in
    function automatic logic [15:0] div_step(input logic [15:0] w, input logic [7:0] p);
        logic [8:0] trial;
        logic [8:0] diff;
        trial = {w[15:8], w[7]};
        diff  = trial - {1'b0, p};
        if (trial >= {1'b0, p})
        begin
            return {diff[7:0], w[6:0], 1'b1};
        end
        return {trial[7:0], w[6:0], 1'b0};
    endfunction

endpackage

// File: hdl/mask_overlay_pixel_colorizer.sv
// mask overlay pixel colorizer: rgb mask pixel in, rgba overlay pixel out
// pipeline: a request accepted at a clock edge shows its result with done high;
//   eight register stages, the last four run the restoring divider two quotient bits each
// throughput: one request per clock; busy stays low, the pipeline never stalls
// reset: rst_n clears all stage valid bits, view_mode to full view, texture_kind to
//   pass-through; payload registers are not reset
module mask_overlay_pixel_colorizer (
    input  logic        clk,
    input  logic        rst_n,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request side
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  in_red,
    input  logic [7:0]  in_green,
    input  logic [7:0]  in_blue,
    // result side
    output logic        done,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic [7:0]  out_alpha
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [2:0] view_mode_reg;
    logic [2:0] texture_kind_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_mode_reg    <= mopc_pkg::VIEW_MODE_RESET;
            texture_kind_reg <= mopc_pkg::TEXTURE_KIND_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                mopc_pkg::REG_VIEW_MODE:    view_mode_reg    <= pwdata[2:0];
                mopc_pkg::REG_TEXTURE_KIND: texture_kind_reg <= pwdata[2:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            mopc_pkg::REG_VIEW_MODE:    prdata = {29'd0, view_mode_reg};
            mopc_pkg::REG_TEXTURE_KIND: prdata = {29'd0, texture_kind_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // no backpressure anywhere, every request enters the pipeline
    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // ------------------------------------------------------------------
    // stage 1: constant products for the semantic tints
    // ------------------------------------------------------------------
    logic        s1_valid_reg;
    logic [7:0]  s1_r_reg, s1_g_reg, s1_b_reg;
    logic [2:0]  s1_mode_reg, s1_kind_reg;
    logic [15:0] s1_r220_reg, s1_g235_reg, s1_r240_reg, s1_r140_reg, s1_g230_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_r_reg    <= in_red;
        s1_g_reg    <= in_green;
        s1_b_reg    <= in_blue;
        s1_mode_reg <= view_mode_reg;
        s1_kind_reg <= texture_kind_reg;
        s1_r220_reg <= 16'(in_red)   * 16'(mopc_pkg::COEF_R220);
        s1_g235_reg <= 16'(in_green) * 16'(mopc_pkg::COEF_G235);
        s1_r240_reg <= 16'(in_red)   * 16'(mopc_pkg::COEF_R240);
        s1_r140_reg <= 16'(in_red)   * 16'(mopc_pkg::COEF_R140);
        s1_g230_reg <= 16'(in_green) * 16'(mopc_pkg::COEF_G230);
    end

    // ------------------------------------------------------------------
    // stage 2: scale products by 1/255 (reciprocal add, exact in range)
    // ------------------------------------------------------------------
    logic       s2_valid_reg;
    logic [7:0] s2_r_reg, s2_g_reg, s2_b_reg;
    logic [2:0] s2_mode_reg, s2_kind_reg;
    logic [7:0] s2_r220_reg, s2_g235_reg, s2_r240_reg, s2_r140_reg, s2_g230_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_r_reg    <= s1_r_reg;
        s2_g_reg    <= s1_g_reg;
        s2_b_reg    <= s1_b_reg;
        s2_mode_reg <= s1_mode_reg;
        s2_kind_reg <= s1_kind_reg;
        s2_r220_reg <= mopc_pkg::div255(s1_r220_reg);
        s2_g235_reg <= mopc_pkg::div255(s1_g235_reg);
        s2_r240_reg <= mopc_pkg::div255(s1_r240_reg);
        s2_r140_reg <= mopc_pkg::div255(s1_r140_reg);
        s2_g230_reg <= mopc_pkg::div255(s1_g230_reg);
    end

    // ------------------------------------------------------------------
    // stage 3: pick the color to normalize and the alpha for the view
    // fixed-tint views carry their color and get divided by 255, which
    // returns it unchanged
    // ------------------------------------------------------------------
    logic                 s3_valid_reg;
    mopc_pkg::lane_byte_t s3_tint_reg;
    logic [7:0]           s3_alpha_reg;
    mopc_pkg::lane_byte_t s3_tint_next;
    logic [7:0]           s3_alpha_next;
    logic [7:0]           s2_peak_in;

    assign s2_peak_in = mopc_pkg::max3(s2_r_reg, s2_g_reg, s2_b_reg);

    always_comb
    begin
        s3_tint_next  = '0;
        s3_alpha_next = 8'd0;
        case (s2_mode_reg)
            mopc_pkg::VIEW_FULL:
            begin
                s3_tint_next  = {s2_b_reg, s2_g_reg, s2_r_reg};
                s3_alpha_next = s2_peak_in;
            end
            mopc_pkg::VIEW_RED:
            begin
                s3_tint_next  = {mopc_pkg::LEVEL_80, mopc_pkg::LEVEL_80,
                                 mopc_pkg::LEVEL_FULL};
                s3_alpha_next = s2_r_reg;
            end
            mopc_pkg::VIEW_GREEN:
            begin
                s3_tint_next  = {mopc_pkg::LEVEL_80, mopc_pkg::LEVEL_FULL,
                                 mopc_pkg::LEVEL_80};
                s3_alpha_next = s2_g_reg;
            end
            mopc_pkg::VIEW_BLUE:
            begin
                s3_tint_next  = {mopc_pkg::LEVEL_FULL, mopc_pkg::LEVEL_140,
                                 mopc_pkg::LEVEL_100};
                s3_alpha_next = s2_b_reg;
            end
            mopc_pkg::VIEW_SEMANTIC:
            begin
                s3_alpha_next = s2_peak_in;
                case (s2_kind_reg)
                    mopc_pkg::KIND_SHADOW:
                    begin
                        s3_tint_next[0] = mopc_pkg::sat8(9'(s2_r_reg) + 9'(s2_g_reg));
                        s3_tint_next[1] = mopc_pkg::sat8(9'(s2_r220_reg) + 9'(s2_g235_reg));
                        s3_tint_next[2] = s2_b_reg;
                    end
                    mopc_pkg::KIND_SUBLIGHT:
                    begin
                        s3_tint_next[0] = mopc_pkg::sat8(9'(s2_r240_reg) + 9'(s2_b_reg));
                        s3_tint_next[1] = mopc_pkg::sat8(9'(s2_r140_reg) + 9'(s2_g230_reg));
                        s3_tint_next[2] = s2_g230_reg;
                    end
                    mopc_pkg::KIND_EDGE:
                    begin
                        s3_tint_next[0] = mopc_pkg::LEVEL_80;
                        s3_tint_next[1] = mopc_pkg::sat8(9'(s2_r_reg) +
                                                         9'(mopc_pkg::EDGE_OFS_G));
                        s3_tint_next[2] = mopc_pkg::sat8(9'(s2_r_reg) +
                                                         9'(mopc_pkg::EDGE_OFS_B));
                    end
                    mopc_pkg::KIND_FACE_DIST:
                    begin
                        s3_tint_next = {s2_r_reg, s2_r_reg, s2_r_reg};
                    end
                    // pass-through, unused kinds included
                    default:
                    begin
                        s3_tint_next = {s2_b_reg, s2_g_reg, s2_r_reg};
                    end
                endcase
            end
            // unused view codes give an all-zero pixel
            default:
            begin
                s3_tint_next  = '0;
                s3_alpha_next = 8'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_tint_reg  <= s3_tint_next;
        s3_alpha_reg <= s3_alpha_next;
    end

    // ------------------------------------------------------------------
    // stage 4: peak of the tint and dividends t*255
    // a zero peak means every tint is zero; dividing by 255 then gives zero
    // ------------------------------------------------------------------
    logic                 s4_valid_reg;
    mopc_pkg::lane_word_t s4_w_reg;
    logic [7:0]           s4_peak_reg;
    logic [7:0]           s4_alpha_reg;
    logic [7:0]           s3_peak;
    mopc_pkg::lane_word_t s4_w_next;

    assign s3_peak = mopc_pkg::max3(s3_tint_reg[0], s3_tint_reg[1], s3_tint_reg[2]);

    always_comb
    begin
        for (int i = 0; i < mopc_pkg::NUM_LANES; i++)
        begin
            s4_w_next[i] = {s3_tint_reg[i], 8'd0} - {8'd0, s3_tint_reg[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_w_reg     <= s4_w_next;
        s4_peak_reg  <= (s3_peak == 8'd0) ? mopc_pkg::LEVEL_FULL : s3_peak;
        s4_alpha_reg <= s3_alpha_reg;
    end

    // ------------------------------------------------------------------
    // divider stages: two restoring steps per stage, three lanes in parallel
    // ------------------------------------------------------------------
    logic                 d1_valid_reg, d2_valid_reg, d3_valid_reg;
    mopc_pkg::lane_word_t d1_w_reg, d2_w_reg, d3_w_reg;
    logic [7:0]           d1_peak_reg, d2_peak_reg, d3_peak_reg;
    logic [7:0]           d1_alpha_reg, d2_alpha_reg, d3_alpha_reg;
    mopc_pkg::lane_word_t d1_w_next, d2_w_next, d3_w_next, q_w_next;

    always_comb
    begin
        for (int i = 0; i < mopc_pkg::NUM_LANES; i++)
        begin
            d1_w_next[i] = mopc_pkg::div_step(mopc_pkg::div_step(s4_w_reg[i], s4_peak_reg),
                                              s4_peak_reg);
            d2_w_next[i] = mopc_pkg::div_step(mopc_pkg::div_step(d1_w_reg[i], d1_peak_reg),
                                              d1_peak_reg);
            d3_w_next[i] = mopc_pkg::div_step(mopc_pkg::div_step(d2_w_reg[i], d2_peak_reg),
                                              d2_peak_reg);
            q_w_next[i]  = mopc_pkg::div_step(mopc_pkg::div_step(d3_w_reg[i], d3_peak_reg),
                                              d3_peak_reg);
        end
    end

    // result registers
    logic       done_reg;
    logic [7:0] out_red_reg, out_green_reg, out_blue_reg, out_alpha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_valid_reg <= 1'b0;
            d2_valid_reg <= 1'b0;
            d3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            d1_valid_reg <= s4_valid_reg;
            d2_valid_reg <= d1_valid_reg;
            d3_valid_reg <= d2_valid_reg;
            done_reg     <= d3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d1_w_reg      <= d1_w_next;
        d1_peak_reg   <= s4_peak_reg;
        d1_alpha_reg  <= s4_alpha_reg;
        d2_w_reg      <= d2_w_next;
        d2_peak_reg   <= d1_peak_reg;
        d2_alpha_reg  <= d1_alpha_reg;
        d3_w_reg      <= d3_w_next;
        d3_peak_reg   <= d2_peak_reg;
        d3_alpha_reg  <= d2_alpha_reg;
        // quotient is in the low byte after the eighth step
        out_red_reg   <= q_w_next[0][7:0];
        out_green_reg <= q_w_next[1][7:0];
        out_blue_reg  <= q_w_next[2][7:0];
        out_alpha_reg <= d3_alpha_reg;
    end

    assign done      = done_reg;
    assign out_red   = out_red_reg;
    assign out_green = out_green_reg;
    assign out_blue  = out_blue_reg;
    assign out_alpha = out_alpha_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // every accepted request yields exactly one result
    a_req_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##8 done)
        else $error("accepted request produced no result");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> ##8 !done)
        else $error("result strobe without a request");

    // divider precondition: dividend high byte below divisor keeps quotient in 8 bits
    a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg |-> (s4_w_reg[0][15:8] < s4_peak_reg) &&
                         (s4_w_reg[1][15:8] < s4_peak_reg) &&
                         (s4_w_reg[2][15:8] < s4_peak_reg))
        else $error("divider input out of range");

endmodule

// File: bench/overlay_pixel_checker.sv
// watches the colorizer's ports, predicts each overlay pixel and compares it with the result
`timescale 1ns / 1ps
module overlay_pixel_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    input  logic        start,
    input  logic        busy,
    input  logic [7:0]  in_red,
    input  logic [7:0]  in_green,
    input  logic [7:0]  in_blue,
    input  logic        done,
    input  logic [7:0]  out_red,
    input  logic [7:0]  out_green,
    input  logic [7:0]  out_blue,
    input  logic [7:0]  out_alpha,
    output int          mismatches,
    output int          pixels_in_flight
);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } overlay_px_t;

    localparam int REPORT_LIMIT = 10;

    logic [2:0]  view_sel;
    logic [2:0]  kind_sel;
    overlay_px_t expected_overlay[$];

    function automatic int clamp_byte(input int v);
        return (v > 255) ? 255 : v;
    endfunction

    function automatic int peak_of(input int a, input int b, input int c);
        int m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic overlay_px_t colorize_pixel(input logic [2:0] view,
                                                   input logic [2:0] kind,
                                                   input logic [7:0] r,
                                                   input logic [7:0] g,
                                                   input logic [7:0] b);
        int          ri;
        int          gi;
        int          bi;
        int          tr;
        int          tg;
        int          tb;
        int          peak;
        overlay_px_t px;
        ri = r;
        gi = g;
        bi = b;
        tr = ri;
        tg = gi;
        tb = bi;
        px = '0;
        case (view)
            mopc_pkg::VIEW_RED:   px = {8'd255, 8'd80, 8'd80, r};
            mopc_pkg::VIEW_GREEN: px = {8'd80, 8'd255, 8'd80, g};
            mopc_pkg::VIEW_BLUE:  px = {8'd100, 8'd140, 8'd255, b};
            mopc_pkg::VIEW_FULL, mopc_pkg::VIEW_SEMANTIC:
            begin
                if (view == mopc_pkg::VIEW_SEMANTIC)
                begin
                    case (kind)
                        mopc_pkg::KIND_SHADOW:
                        begin
                            tr = clamp_byte(ri + gi);
                            tg = clamp_byte(ri * 220 / 255 + gi * 235 / 255);
                            tb = bi;
                        end
                        mopc_pkg::KIND_SUBLIGHT:
                        begin
                            tr = clamp_byte(ri * 240 / 255 + bi);
                            tg = clamp_byte(ri * 140 / 255 + gi * 230 / 255);
                            tb = gi * 230 / 255;
                        end
                        mopc_pkg::KIND_EDGE:
                        begin
                            tr = 80;
                            tg = clamp_byte(ri + 40);
                            tb = clamp_byte(ri + 60);
                        end
                        mopc_pkg::KIND_FACE_DIST:
                        begin
                            tr = ri;
                            tg = ri;
                            tb = ri;
                        end
                        default: ;
                    endcase
                end
                // scale the tint so its peak lands on full level
                peak = peak_of(tr, tg, tb);
                if (peak > 0)
                begin
                    px.red   = 8'(clamp_byte(tr * 255 / peak));
                    px.green = 8'(clamp_byte(tg * 255 / peak));
                    px.blue  = 8'(clamp_byte(tb * 255 / peak));
                end
                px.alpha = 8'(peak_of(ri, gi, bi));
            end
            default: px = '0;
        endcase
        return px;
    endfunction

    task automatic report_mismatch(input string what, input overlay_px_t want,
                                   input overlay_px_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
        begin
            $display(
                "%0t overlay %s: expected r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
                $realtime, what, want.red, want.green, want.blue, want.alpha,
                got.red, got.green, got.blue, got.alpha);
        end
    endtask

    always @(posedge clk)
    begin
        overlay_px_t got;
        overlay_px_t want;
        logic [31:0] reg_value;
        if (!rst_n)
        begin
            view_sel = mopc_pkg::VIEW_MODE_RESET;
            kind_sel = mopc_pkg::TEXTURE_KIND_RESET;
            expected_overlay.delete();
        end
        else
        begin
            // result side
            if (done !== 1'b0)
            begin
                got = {out_red, out_green, out_blue, out_alpha};
                if (expected_overlay.size() == 0)
                begin
                    report_mismatch("result with no request", '0, got);
                end
                else
                begin
                    want = expected_overlay.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.alpha !== want.alpha)
                    begin
                        report_mismatch("mismatch", want, got);
                    end
                end
            end
            // request side, predicted with the settings in force before this edge
            if (start === 1'b1 && busy === 1'b0)
            begin
                expected_overlay.push_back(colorize_pixel(view_sel, kind_sel,
                                                          in_red, in_green, in_blue));
            end
            // register port
            if (psel === 1'b1 && penable === 1'b1 && pready === 1'b1)
            begin
                if (pwrite === 1'b1)
                begin
                    if (paddr[2] == mopc_pkg::REG_TEXTURE_KIND)
                        kind_sel = pwdata[2:0];
                    else
                        view_sel = pwdata[2:0];
                end
                else
                begin
                    reg_value = {29'd0, (paddr[2] == mopc_pkg::REG_TEXTURE_KIND) ?
                                        kind_sel : view_sel};
                    if (prdata !== reg_value)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t register read at %0d: expected %0d, got %0d",
                                     $realtime, paddr, reg_value, prdata);
                    end
                end
            end
        end
        pixels_in_flight = expected_overlay.size();
    end

endmodule

// File: bench/tb_mask_overlay_pixel_colorizer.sv
// testbench top for the mask overlay pixel colorizer: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb_mask_overlay_pixel_colorizer;

    // run guard, far above the slowest correct run (about 700 requests, long sender gaps)
    localparam int MAX_CYCLES       = 200000;
    // pipeline is eight stages deep, wait a bit longer for stray results
    localparam int DRAIN_CYCLES     = 12;
    localparam int RANDOM_PHASES    = 26;
    localparam int PIXELS_PER_PHASE = 25;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic        start    = 1'b0;
    logic [7:0]  in_red   = '0;
    logic [7:0]  in_green = '0;
    logic [7:0]  in_blue  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        busy;
    logic        done;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [7:0]  out_alpha;
    int          mismatches;
    int          pixels_in_flight;
    int          cycle_count = 0;

    mask_overlay_pixel_colorizer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .start     (start),
        .busy      (busy),
        .in_red    (in_red),
        .in_green  (in_green),
        .in_blue   (in_blue),
        .done      (done),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .out_alpha (out_alpha)
    );

    overlay_pixel_checker overlay_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .start            (start),
        .busy             (busy),
        .in_red           (in_red),
        .in_green         (in_green),
        .in_blue          (in_blue),
        .done             (done),
        .out_red          (out_red),
        .out_green        (out_green),
        .out_blue         (out_blue),
        .out_alpha        (out_alpha),
        .mismatches       (mismatches),
        .pixels_in_flight (pixels_in_flight)
    );

    always #5 clk = ~clk;

    // hard stop if the run hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("tb_mask_overlay_pixel_colorizer: done, errors");
            $finish;
        end
    end

    // register i sits at byte address 4*i
    function automatic logic [2:0] reg_addr(input logic idx);
        return {idx, 2'b00};
    endfunction

    // channel level biased toward the ends of the range
    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(0, 3));
            3:       return 8'($urandom_range(252, 255));
            default: return 8'($urandom);
        endcase
    endfunction

    // one register transfer, setup then access; the bus is left selected so
    // transfers can run back to back, the caller releases it
    task automatic reg_access(input logic is_write, input logic idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= reg_addr(idx);
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
    endtask

    // lets every request in flight come out; checked at the falling edge so the
    // checker's count for this cycle is settled, returns on a rising edge
    task automatic wait_drained();
        @(negedge clk);
        while (pixels_in_flight != 0) @(negedge clk);
        @(posedge clk);
    endtask

    // registers only change while nothing is in flight; spare upper bits carry
    // noise since only the low three bits are kept, then both are read back
    task automatic configure(input logic [2:0] view, input logic [2:0] kind);
        start <= 1'b0;
        wait_drained();
        reg_access(1'b1, mopc_pkg::REG_VIEW_MODE, {29'($urandom), view});
        reg_access(1'b1, mopc_pkg::REG_TEXTURE_KIND, {29'($urandom), kind});
        reg_access(1'b0, mopc_pkg::REG_VIEW_MODE, '0);
        reg_access(1'b0, mopc_pkg::REG_TEXTURE_KIND, '0);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one pixel request; the sender idles at random first, with junk on the
    // channels, and start stays high into the next request when there is no gap
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start    <= 1'b0;
            in_red   <= 8'($urandom);
            in_green <= 8'($urandom);
            in_blue  <= 8'($urandom);
            @(posedge clk);
        end
        start    <= 1'b1;
        in_red   <= r;
        in_green <= g;
        in_blue  <= b;
        do @(posedge clk); while (busy === 1'b1);
    endtask

    initial
    begin
        logic [2:0] view;
        logic [2:0] kind;
        int         idle_pct;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full view: zero alpha, saturated and single-channel pixels, tiny values
        configure(mopc_pkg::VIEW_FULL, mopc_pkg::KIND_PASS);
        send_pixel(8'd0, 8'd0, 8'd0, 17);
        send_pixel(8'd255, 8'd255, 8'd255, 17);
        send_pixel(8'd255, 8'd0, 8'd0, 17);
        send_pixel(8'd0, 8'd255, 8'd0, 17);
        send_pixel(8'd0, 8'd0, 8'd255, 17);
        send_pixel(8'd1, 8'd2, 8'd3, 17);
        send_pixel(8'd255, 8'd1, 8'd128, 17);

        // single-channel views: fixed tint, alpha follows one channel
        configure(mopc_pkg::VIEW_RED, mopc_pkg::KIND_PASS);
        send_pixel(8'd200, 8'd100, 8'd50, 17);
        configure(mopc_pkg::VIEW_GREEN, mopc_pkg::KIND_PASS);
        send_pixel(8'd200, 8'd100, 8'd50, 17);
        configure(mopc_pkg::VIEW_BLUE, mopc_pkg::KIND_PASS);
        send_pixel(8'd200, 8'd100, 8'd50, 17);

        // unused view codes give an all-zero pixel
        for (int v = mopc_pkg::VIEW_SEMANTIC + 1; v < 8; v++)
        begin
            configure(3'(v), mopc_pkg::KIND_PASS);
            send_pixel(8'd90, 8'd180, 8'd255, 17);
        end

        // semantic view: zero tint peak, clamped sums, every kind
        configure(mopc_pkg::VIEW_SEMANTIC, mopc_pkg::KIND_SHADOW);
        send_pixel(8'd0, 8'd0, 8'd0, 17);
        send_pixel(8'd255, 8'd255, 8'd255, 17);
        configure(mopc_pkg::VIEW_SEMANTIC, mopc_pkg::KIND_SUBLIGHT);
        send_pixel(8'd255, 8'd255, 8'd255, 17);
        send_pixel(8'd0, 8'd0, 8'd200, 17);
        configure(mopc_pkg::VIEW_SEMANTIC, mopc_pkg::KIND_EDGE);
        send_pixel(8'd255, 8'd0, 8'd0, 17);
        send_pixel(8'd0, 8'd9, 8'd9, 17);
        configure(mopc_pkg::VIEW_SEMANTIC, mopc_pkg::KIND_FACE_DIST);
        // zero tint peak while alpha is not zero
        send_pixel(8'd0, 8'd200, 8'd100, 17);
        send_pixel(8'd77, 8'd1, 8'd1, 17);
        configure(mopc_pkg::VIEW_SEMANTIC, mopc_pkg::KIND_PASS);
        send_pixel(8'd0, 8'd0, 8'd0, 17);
        // unused kind code falls back to pass-through
        configure(mopc_pkg::VIEW_SEMANTIC, 3'(mopc_pkg::KIND_PASS + 3));
        send_pixel(8'd10, 8'd20, 8'd30, 17);

        // random part: sweep every view code, then every kind, then mixed settings;
        // sender gaps go light, heavy, then none
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p < 8)
            begin
                view = 3'(p);
                kind = 3'($urandom_range(0, 7));
            end
            else if (p < 16)
            begin
                view = mopc_pkg::VIEW_SEMANTIC;
                kind = 3'(p - 8);
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       view = mopc_pkg::VIEW_FULL;
                    1:       view = mopc_pkg::VIEW_SEMANTIC;
                    default: view = 3'($urandom_range(0, 7));
                endcase
                kind = 3'($urandom_range(0, 7));
            end
            idle_pct = (p < 9) ? 17 : ((p < 18) ? 81 : 0);
            configure(view, kind);
            for (int n = 0; n < PIXELS_PER_PHASE; n++)
                send_pixel(pick_level(), pick_level(), pick_level(), idle_pct);
        end

        // let the pipeline empty, then watch a little longer for stray results
        start <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_mask_overlay_pixel_colorizer: done, clean");
        else
            $display("tb_mask_overlay_pixel_colorizer: done, errors");
        $finish;
    end

endmodule

// File: sim.f
hdl/mopc_pkg.sv
hdl/mask_overlay_pixel_colorizer.sv
bench/overlay_pixel_checker.sv
bench/tb_mask_overlay_pixel_colorizer.sv
